// ===== sv/lac_pkg.sv =====
`default_nettype none
package lac_pkg;

	// Frame store geometry
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int MAX_LAYERS  = 64;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int LAYER_W     = $clog2(MAX_LAYERS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	// Two-entry queues between and after the halves
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHAN_MAX = 8'd255;

	// Configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LAYER_COUNT  = 2'd2;

	typedef struct packed {
		logic [8:0] frame_width;
		logic [8:0] frame_height;
		logic [6:0] layer_count;
	} cfg_t;

	// Word passed from the front half to the back half
	typedef struct packed {
		logic [7:0]        src_red;
		logic [7:0]        src_green;
		logic [7:0]        src_blue;
		logic [7:0]        src_alpha;
		logic [ADDR_W-1:0] addr;
		logic [COL_W-1:0]  x;
		logic [ROW_W-1:0]  y;
		logic              first_layer;
		logic              final_layer;
		logic              frame_done;
	} item_t;

	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       alpha;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic             final_layer;
		logic             frame_done;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL1,
		BK_DIV1,
		BK_MUL2,
		BK_DIV2
	} bk_state_t;

	// Exact x / 255 for x up to 2*255*255, the largest sum the blend forms:
	// estimate by x*257 >> 16 (never high, at most one low), then one
	// compare and correct on the remainder.
	function automatic logic [8:0] div255(input logic [16:0] x);
		logic [25:0] p;
		logic [8:0]  q;
		logic [17:0] qm;
		logic [17:0] r;
		p  = ({9'd0, x} << 8) + {9'd0, x};
		q  = p[24:16];
		qm = {1'b0, q, 8'd0} - {9'd0, q};
		r  = {1'b0, x} - qm;
		if (r >= 18'd255) begin
			q = q + 9'd1;
		end
		return q;
	endfunction

	// Clamp to the channel range
	function automatic logic [7:0] sat8(input logic [8:0] v);
		return (v > {1'b0, CHAN_MAX}) ? CHAN_MAX : v[7:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/lac_front.sv =====
`default_nettype none
// Front half: takes pixels, keeps the raster and layer counters, tags each
// word with its store address and frame flags, and queues it for the back.
module lac_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lac_pkg::cfg_t  cfg,
	input  wire logic           push,
	output logic                full,
	input  wire logic [7:0]     src_red,
	input  wire logic [7:0]     src_green,
	input  wire logic [7:0]     src_blue,
	input  wire logic [7:0]     src_alpha,
	output logic                q_empty,
	input  wire logic           q_pop,
	output lac_pkg::item_t      q_word
);

	logic [lac_pkg::COL_W-1:0]   col_q;
	logic [lac_pkg::ROW_W-1:0]   row_q;
	logic [lac_pkg::LAYER_W-1:0] layer_q;

	logic [lac_pkg::COL_W-1:0]   col_last;
	logic [lac_pkg::ROW_W-1:0]   row_last;
	logic [lac_pkg::LAYER_W-1:0] layer_last;
	logic                        last_col, last_row, last_layer;
	logic                        acc;
	lac_pkg::item_t              wr_word;

	lac_pkg::item_t              q_mem [lac_pkg::QDEPTH];
	logic [lac_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [lac_pkg::QCNT_W-1:0]  q_cnt_q;

	// Last position of each counter; zero sizes act as one, big ones clamp
	always_comb begin
		priority if (cfg.frame_width <= 9'd1) begin
			col_last = '0;
		end else if (cfg.frame_width > 9'(lac_pkg::MAX_WIDTH)) begin
			col_last = lac_pkg::COL_W'(lac_pkg::MAX_WIDTH - 1);
		end else begin
			col_last = lac_pkg::COL_W'(cfg.frame_width - 9'd1);
		end
		priority if (cfg.frame_height <= 9'd1) begin
			row_last = '0;
		end else if (cfg.frame_height > 9'(lac_pkg::MAX_HEIGHT)) begin
			row_last = lac_pkg::ROW_W'(lac_pkg::MAX_HEIGHT - 1);
		end else begin
			row_last = lac_pkg::ROW_W'(cfg.frame_height - 9'd1);
		end
		priority if (cfg.layer_count <= 7'd1) begin
			layer_last = '0;
		end else if (cfg.layer_count > 7'(lac_pkg::MAX_LAYERS)) begin
			layer_last = lac_pkg::LAYER_W'(lac_pkg::MAX_LAYERS - 1);
		end else begin
			layer_last = lac_pkg::LAYER_W'(cfg.layer_count - 7'd1);
		end
	end

	assign last_col   = (col_q >= col_last);
	assign last_row   = (row_q >= row_last);
	assign last_layer = (layer_q >= layer_last);

	assign full = (q_cnt_q == lac_pkg::QCNT_W'(lac_pkg::QDEPTH));
	assign acc  = push && !full;

	// Classify the incoming word
	always_comb begin
		wr_word.src_red     = src_red;
		wr_word.src_green   = src_green;
		wr_word.src_blue    = src_blue;
		wr_word.src_alpha   = src_alpha;
		wr_word.addr        = lac_pkg::ADDR_W'(row_q * lac_pkg::MAX_WIDTH + col_q);
		wr_word.x           = col_q;
		wr_word.y           = row_q;
		wr_word.first_layer = (layer_q == '0);
		wr_word.final_layer = last_layer;
		wr_word.frame_done  = last_col && last_row && last_layer;
	end

	// Raster and layer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			layer_q <= '0;
		end else if (acc) begin
			if (!last_col) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_q + 1'b1;
				end else begin
					row_q   <= '0;
					layer_q <= last_layer ? '0 : layer_q + 1'b1;
				end
			end
		end
	end

	// Queue towards the back half
	always_ff @(posedge clk) begin
		if (acc) begin
			q_mem[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop && !q_empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({acc, q_pop && !q_empty})
				2'b10:   q_cnt_q <= q_cnt_q + 1'b1;
				2'b01:   q_cnt_q <= q_cnt_q - 1'b1;
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

	assign q_empty = (q_cnt_q == '0);
	assign q_word  = q_mem[rd_ptr_q];

	a_qcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= lac_pkg::QCNT_W'(lac_pkg::QDEPTH))
		else $error("front queue count out of range");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && wr_word.frame_done) |=> (col_q == '0 && row_q == '0 && layer_q == '0))
		else $error("counters did not wrap after the last pixel of a frame");

	a_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (!wr_word.frame_done || wr_word.final_layer))
		else $error("frame done outside the last layer");

endmodule
`default_nettype wire

// ===== sv/lac_back.sv =====
`default_nettype none
// Back half: read-modify-write of the frame store, one word at a time.
// Read, products, divide by 255, products and sum, divide and write back.
module lac_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_empty,
	output logic                 q_pop,
	input  wire lac_pkg::item_t  q_word,
	output logic                 empty,
	input  wire logic            pop,
	output lac_pkg::result_t     res
);

	lac_pkg::bk_state_t state_q, state_d;

	logic [31:0] store_mem [lac_pkg::STORE_DEPTH];
	logic [31:0] rdata_q;
	logic        mem_re, mem_we;
	logic [31:0] wdata;

	lac_pkg::item_t item_q;
	logic           start;

	logic [7:0]  src_c [3];
	logic [7:0]  dst_c [3];
	logic [31:0] dst;
	logic [7:0]  inv_a;

	logic [15:0] t1_q  [3];
	logic [15:0] ss_q  [3];
	logic [15:0] ta_q;
	logic [7:0]  da_q;
	logic [7:0]  q1_q  [3];
	logic [7:0]  qa_q;
	logic [16:0] sum_q [3];
	logic [8:0]  oa_q;

	logic [8:0]  q1_d  [3];
	logic [8:0]  qa_d;
	logic [8:0]  qo_d  [3];
	logic [7:0]  o_c   [3];
	logic [7:0]  o_a;

	lac_pkg::result_t           out_word;
	logic                       out_push;
	lac_pkg::result_t           out_mem [lac_pkg::QDEPTH];
	logic [lac_pkg::QPTR_W-1:0] owr_ptr_q, ord_ptr_q;
	logic [lac_pkg::QCNT_W-1:0] out_cnt_q;
	logic                       out_full;

	assign out_full = (out_cnt_q == lac_pkg::QCNT_W'(lac_pkg::QDEPTH));
	assign start    = (state_q == lac_pkg::BK_IDLE) && !q_empty && !out_full;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lac_pkg::BK_IDLE: if (start) begin
				state_d = lac_pkg::BK_MUL1;
			end
			lac_pkg::BK_MUL1: state_d = lac_pkg::BK_DIV1;
			lac_pkg::BK_DIV1: state_d = lac_pkg::BK_MUL2;
			lac_pkg::BK_MUL2: state_d = lac_pkg::BK_DIV2;
			lac_pkg::BK_DIV2: state_d = lac_pkg::BK_IDLE;
			default:          state_d = lac_pkg::BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		q_pop    = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		out_push = 1'b0;
		unique case (state_q)
			lac_pkg::BK_IDLE: begin
				q_pop  = start;
				mem_re = start;
			end
			lac_pkg::BK_DIV2: begin
				mem_we   = 1'b1;
				out_push = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lac_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[item_q.addr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= store_mem[q_word.addr];
		end
	end

	// Datapath operands; first layer blends over zero
	always_comb begin
		dst      = item_q.first_layer ? 32'd0 : rdata_q;
		src_c[0] = item_q.src_red;
		src_c[1] = item_q.src_green;
		src_c[2] = item_q.src_blue;
		dst_c[0] = dst[7:0];
		dst_c[1] = dst[15:8];
		dst_c[2] = dst[23:16];
		inv_a    = lac_pkg::CHAN_MAX - item_q.src_alpha;
		for (int c = 0; c < 3; c++) begin
			q1_d[c] = lac_pkg::div255({1'b0, t1_q[c]});
			qo_d[c] = lac_pkg::div255(sum_q[c]);
			o_c[c]  = lac_pkg::sat8(qo_d[c]);
		end
		qa_d = lac_pkg::div255({1'b0, ta_q});
		o_a  = lac_pkg::sat8(oa_q);
	end

	// Stage registers, loaded in their own state
	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= q_word;
		end
		unique case (state_q)
			lac_pkg::BK_MUL1: begin
				for (int c = 0; c < 3; c++) begin
					t1_q[c] <= {8'd0, dst_c[c]} * {8'd0, inv_a};
					ss_q[c] <= {8'd0, src_c[c]} * {8'd0, item_q.src_alpha};
				end
				ta_q <= {8'd0, dst[31:24]} * {8'd0, inv_a};
				da_q <= dst[31:24];
			end
			lac_pkg::BK_DIV1: begin
				for (int c = 0; c < 3; c++) begin
					q1_q[c] <= q1_d[c][7:0];
				end
				qa_q <= qa_d[7:0];
			end
			lac_pkg::BK_MUL2: begin
				for (int c = 0; c < 3; c++) begin
					sum_q[c] <= {1'b0, ss_q[c]} + {1'b0, {8'd0, q1_q[c]} * {8'd0, da_q}};
				end
				oa_q <= {1'b0, item_q.src_alpha} + {1'b0, qa_q};
			end
			default: begin
			end
		endcase
	end

	assign wdata = {o_a, o_c[2], o_c[1], o_c[0]};

	always_comb begin
		out_word.red         = o_c[0];
		out_word.green       = o_c[1];
		out_word.blue        = o_c[2];
		out_word.alpha       = o_a;
		out_word.x           = item_q.x;
		out_word.y           = item_q.y;
		out_word.final_layer = item_q.final_layer;
		out_word.frame_done  = item_q.frame_done;
	end

	// Result queue
	always_ff @(posedge clk) begin
		if (out_push) begin
			out_mem[owr_ptr_q] <= out_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			out_cnt_q <= '0;
		end else begin
			if (out_push) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			unique case ({out_push, pop && !empty})
				2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
				2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	assign empty = (out_cnt_q == '0);
	assign res   = out_mem[ord_ptr_q];

	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= lac_pkg::QCNT_W'(lac_pkg::QDEPTH))
		else $error("result queue count out of range");

	a_room_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into a full queue");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == lac_pkg::BK_IDLE && !mem_we))
		else $error("store write not followed by idle");

endmodule
`default_nettype wire

// ===== sv/layer_alpha_compositor_core.sv =====
`default_nettype none
// Layer compositor: blends RGBA8 pixels "over" a 256x256 frame store, layer
// by layer in raster order, and returns every updated pixel with its column,
// row and last-layer / end-of-frame flags. Input is a queue (push/full),
// results a queue (empty/pop). Each pixel steps through the back half in turn
// (store read, product, divide by 255, product and sum, divide and write);
// no new pixel starts until the last is written back, nor while the result
// queue is full, as there is a single read-modify-write path into the frame
// store; a two-word queue in front lets the source keep pushing meanwhile. The
// store is not cleared: the first layer blends over zero. Sizes take effect at
// once and should only change between frames while the block is idle.
module layer_alpha_compositor_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] src_red,
	input  wire logic [7:0] src_green,
	input  wire logic [7:0] src_blue,
	input  wire logic [7:0] src_alpha,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_red,
	output logic [7:0]      out_green,
	output logic [7:0]      out_blue,
	output logic [7:0]      out_alpha,
	output logic [7:0]      pixel_x,
	output logic [7:0]      pixel_y,
	output logic            final_layer,
	output logic            frame_done
);

	lac_pkg::cfg_t    cfg_q;
	lac_pkg::item_t   q_word;
	lac_pkg::result_t res;
	logic             q_empty, q_pop;

	assign cfg_ready = 1'b1;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= 9'd1;
			cfg_q.frame_height <= 9'd1;
			cfg_q.layer_count  <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lac_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				lac_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				lac_pkg::REG_LAYER_COUNT:  cfg_q.layer_count  <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	lac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.src_red   (src_red),
		.src_green (src_green),
		.src_blue  (src_blue),
		.src_alpha (src_alpha),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_word    (q_word)
	);

	lac_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_word  (q_word),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign out_red     = res.red;
	assign out_green   = res.green;
	assign out_blue    = res.blue;
	assign out_alpha   = res.alpha;
	assign pixel_x     = res.x;
	assign pixel_y     = res.y;
	assign final_layer = res.final_layer;
	assign frame_done  = res.frame_done;

endmodule
`default_nettype wire
